### rtl/core/rgb_pixel_store_sad_fitness_macros.svh
`ifndef RGB_PIXEL_STORE_SAD_FITNESS_MACROS_SVH
`define RGB_PIXEL_STORE_SAD_FITNESS_MACROS_SVH

// Same-cycle implication, sampled on aclk and disabled in reset.
`define RPSF_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on aclk and disabled in reset.
`define RPSF_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/core/rpsf_pkg.sv
package rpsf_pkg;

    localparam int PIXELS      = 1024;
    localparam int ADDR_W      = $clog2(PIXELS);
    localparam int COUNT_W     = 11;
    localparam int POS_W       = 11;
    localparam int TOTAL_W     = 20;
    localparam int SAD_W       = 10;
    localparam int FIT_W       = 16;
    localparam int STATUS_W    = 2;
    localparam int DIVISOR_W   = 12;

    localparam logic [COUNT_W-1:0] GENE_COUNT_RESET = 11'd1024;
    localparam logic [POS_W-1:0]   POS_MAX          = 11'd2047;
    // Reciprocal of three scaled by 2^19, rounded up; exact for inputs below 2^19.
    localparam logic [17:0]        RECIP3           = 18'd174763;

    localparam logic [1:0] OP_WRITE   = 2'd0;
    localparam logic [1:0] OP_READ    = 2'd1;
    localparam logic [1:0] OP_GENE    = 2'd2;
    localparam logic [1:0] OP_COMPARE = 2'd3;

    localparam logic [STATUS_W-1:0] STATUS_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_RANGE    = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_MISMATCH = 2'd2;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } pixel_t;

    typedef struct packed {
        logic              we;
        logic              re;
        logic [ADDR_W-1:0] addr;
        pixel_t            wdata;
    } ram_req_t;

    typedef struct packed {
        logic               start;
        logic [TOTAL_W-1:0] total;
        logic [COUNT_W-1:0] count;
    } div_req_t;

    typedef struct packed {
        logic             done;
        logic [FIT_W-1:0] quotient;
    } div_rsp_t;

    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_EXEC,
        S_DIV
    } state_t;

    function automatic logic [7:0] abs_diff8(input logic [7:0] a, input logic [7:0] b);
        return (a > b) ? (a - b) : (b - a);
    endfunction

    function automatic logic [SAD_W-1:0] pixel_sad(input pixel_t a, input pixel_t b);
        return {2'b00, abs_diff8(a.red, b.red)} + {2'b00, abs_diff8(a.green, b.green)}
             + {2'b00, abs_diff8(a.blue, b.blue)};
    endfunction

endpackage

### rtl/core/rgb_pixel_store_sad_fitness.sv
// Sequence: an accepted item goes to S_EXEC, where its result is registered once the output
// is free; the last item of a matching compare run instead starts the 16-step divider.
// Flow: s_ready is high only in S_IDLE, so a new item waits until the last result is taken
// into the output register; the single-port pixel memory is read when an item is accepted.
// Reset: gene_count returns to 1024; a pass in S_CLEAR then clears all 1024 pixel memory
// words, during which s_ready stays low and configuration beats are still taken.
module rgb_pixel_store_sad_fitness (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [rpsf_pkg::COUNT_W-1:0]      cfg_gene_count,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic [1:0]                        s_opcode,
    input  logic [rpsf_pkg::ADDR_W-1:0]       s_pixel_index,
    input  logic [7:0]                        s_red,
    input  logic [7:0]                        s_green,
    input  logic [7:0]                        s_blue,
    input  logic                              s_last_target,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic [rpsf_pkg::STATUS_W-1:0]     m_status,
    output logic [7:0]                        m_out_red,
    output logic [7:0]                        m_out_green,
    output logic [7:0]                        m_out_blue,
    output logic [rpsf_pkg::FIT_W-1:0]        m_fitness,
    output logic                              m_run_done
);
    import rpsf_pkg::*;

    state_t               state_reg, state_next;
    logic [ADDR_W-1:0]    clr_cnt_reg, clr_cnt_next;
    logic [COUNT_W-1:0]   gene_count_reg;
    logic [1:0]           op_reg, op_next;
    logic                 inr_reg, inr_next;
    pixel_t               tgt_reg, tgt_next;
    logic                 last_reg, last_next;
    logic [POS_W-1:0]     pos_reg, pos_next;
    logic [TOTAL_W-1:0]   diff_total_reg, diff_total_next;
    logic [POS_W-1:0]     cmp_pos_reg, cmp_pos_next;
    logic                 m_valid_reg, m_valid_next;
    logic [STATUS_W-1:0]  status_reg, status_next;
    pixel_t               pix_out_reg, pix_out_next;
    logic [FIT_W-1:0]     fitness_reg, fitness_next;
    logic                 run_done_reg, run_done_next;

    ram_req_t             ram_req;
    pixel_t               ram_rdata;
    div_req_t             div_req;
    div_rsp_t             div_rsp;

    logic                 out_free;
    logic [POS_W-1:0]     access_idx;
    logic                 access_inr;
    logic [SAD_W-1:0]     sad;
    logic [27:0]          gene_prod;
    logic [TOTAL_W-1:0]   total_sum;
    logic [COUNT_W:0]     run_count;
    logic                 run_match;

    rpsf_ram u_ram (
        .aclk  (aclk),
        .req   (ram_req),
        .rdata (ram_rdata)
    );

    rpsf_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (div_req),
        .rsp     (div_rsp)
    );

    assign cfg_ready = 1'b1;
    assign s_ready   = (state_reg == S_IDLE);
    assign out_free  = !m_valid_reg || m_ready;

    assign access_idx = (s_opcode == OP_COMPARE) ? cmp_pos_reg : {1'b0, s_pixel_index};
    assign access_inr = (access_idx < gene_count_reg) && (access_idx < POS_W'(PIXELS));

    assign sad       = pixel_sad(ram_rdata, tgt_reg);
    assign gene_prod = {18'b0, sad} * {10'b0, RECIP3};
    assign total_sum = diff_total_reg + (inr_reg ? TOTAL_W'(sad) : '0);
    assign run_count = {1'b0, pos_reg} + 12'd1;
    assign run_match = (run_count == {1'b0, gene_count_reg})
                    && (gene_count_reg <= COUNT_W'(PIXELS));

    always_comb begin
        state_next      = state_reg;
        clr_cnt_next    = clr_cnt_reg;
        op_next         = op_reg;
        inr_next        = inr_reg;
        tgt_next        = tgt_reg;
        last_next       = last_reg;
        pos_next        = pos_reg;
        diff_total_next = diff_total_reg;
        cmp_pos_next    = cmp_pos_reg;
        m_valid_next    = m_valid_reg && !m_ready;
        status_next     = status_reg;
        pix_out_next    = pix_out_reg;
        fitness_next    = fitness_reg;
        run_done_next   = run_done_reg;
        ram_req         = '0;
        div_req.start   = 1'b0;
        div_req.total   = total_sum;
        div_req.count   = run_count[COUNT_W-1:0];

        case (state_reg)
            S_CLEAR: begin
                ram_req.we   = 1'b1;
                ram_req.addr = clr_cnt_reg;
                clr_cnt_next = clr_cnt_reg + 1'b1;
                if (clr_cnt_reg == ADDR_W'(PIXELS - 1)) begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE: begin
                if (s_valid) begin
                    op_next       = s_opcode;
                    inr_next      = access_inr;
                    tgt_next      = '{red: s_red, green: s_green, blue: s_blue};
                    last_next     = s_last_target;
                    pos_next      = cmp_pos_reg;
                    ram_req.addr  = access_idx[ADDR_W-1:0];
                    ram_req.wdata = '{red: s_red, green: s_green, blue: s_blue};
                    ram_req.we    = (s_opcode == OP_WRITE) && access_inr;
                    ram_req.re    = (s_opcode != OP_WRITE);
                    state_next    = S_EXEC;
                end
            end
            S_EXEC: begin
                if (out_free) begin
                    status_next   = inr_reg ? STATUS_OK : STATUS_RANGE;
                    pix_out_next  = '0;
                    fitness_next  = '0;
                    run_done_next = 1'b0;
                    m_valid_next  = 1'b1;
                    state_next    = S_IDLE;
                    case (op_reg)
                        OP_WRITE: begin
                        end
                        OP_READ: begin
                            if (inr_reg) begin
                                pix_out_next = ram_rdata;
                            end
                        end
                        OP_GENE: begin
                            if (inr_reg) begin
                                fitness_next = gene_prod[26:11];
                            end
                        end
                        OP_COMPARE: begin
                            status_next = STATUS_OK;
                            if (last_reg) begin
                                diff_total_next = '0;
                                cmp_pos_next    = '0;
                                if (run_match) begin
                                    div_req.start = 1'b1;
                                    m_valid_next  = m_valid_reg && !m_ready;
                                    state_next    = S_DIV;
                                end else begin
                                    status_next = STATUS_MISMATCH;
                                end
                            end else begin
                                diff_total_next = total_sum;
                                if (pos_reg != POS_MAX) begin
                                    cmp_pos_next = pos_reg + 1'b1;
                                end
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_DIV: begin
                if (div_rsp.done && out_free) begin
                    status_next   = STATUS_OK;
                    pix_out_next  = '0;
                    fitness_next  = div_rsp.quotient;
                    run_done_next = 1'b1;
                    m_valid_next  = 1'b1;
                    state_next    = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= S_CLEAR;
            clr_cnt_reg    <= '0;
            gene_count_reg <= GENE_COUNT_RESET;
            diff_total_reg <= '0;
            cmp_pos_reg    <= '0;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg      <= state_next;
            clr_cnt_reg    <= clr_cnt_next;
            diff_total_reg <= diff_total_next;
            cmp_pos_reg    <= cmp_pos_next;
            m_valid_reg    <= m_valid_next;
            if (cfg_valid && cfg_ready) begin
                gene_count_reg <= cfg_gene_count;
            end
        end
    end

    always_ff @(posedge aclk) begin
        op_reg       <= op_next;
        inr_reg      <= inr_next;
        tgt_reg      <= tgt_next;
        last_reg     <= last_next;
        pos_reg      <= pos_next;
        status_reg   <= status_next;
        pix_out_reg  <= pix_out_next;
        fitness_reg  <= fitness_next;
        run_done_reg <= run_done_next;
    end

    assign m_valid     = m_valid_reg;
    assign m_status    = status_reg;
    assign m_out_red   = pix_out_reg.red;
    assign m_out_green = pix_out_reg.green;
    assign m_out_blue  = pix_out_reg.blue;
    assign m_fitness   = fitness_reg;
    assign m_run_done  = run_done_reg;

endmodule

### rtl/core/rpsf_ram.sv
module rpsf_ram (
    input  logic              aclk,
    input  rpsf_pkg::ram_req_t req,
    output rpsf_pkg::pixel_t  rdata
);
    import rpsf_pkg::*;

    pixel_t mem [0:PIXELS-1];
    pixel_t rdata_reg;

    always_ff @(posedge aclk) begin
        if (req.we) begin
            mem[req.addr] <= req.wdata;
        end
        if (req.re) begin
            rdata_reg <= mem[req.addr];
        end
    end

    assign rdata = rdata_reg;

endmodule

### rtl/core/rpsf_div.sv
module rpsf_div (
    input  logic              aclk,
    input  logic              aresetn,
    input  rpsf_pkg::div_req_t req,
    output rpsf_pkg::div_rsp_t rsp
);
    import rpsf_pkg::*;

    // Computes floor(total * 256 / (3 * count)), one quotient bit per cycle.
    // The caller guarantees total <= 765 * count, so the quotient fits 16 bits.
    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic [3:0]           step_reg, step_next;
    logic [DIVISOR_W-1:0] rem_reg, rem_next;
    logic [DIVISOR_W-1:0] den_reg, den_next;
    logic [FIT_W-1:0]     sh_reg, sh_next;
    logic [FIT_W-1:0]     q_reg, q_next;
    logic [DIVISOR_W:0]   rem_shift;
    logic [DIVISOR_W:0]   rem_sub;
    logic                 fits;

    always_comb begin
        busy_next = busy_reg;
        done_next = done_reg;
        step_next = step_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        sh_next   = sh_reg;
        q_next    = q_reg;
        rem_shift = {rem_reg, sh_reg[FIT_W-1]};
        rem_sub   = rem_shift - {1'b0, den_reg};
        fits      = (rem_shift >= {1'b0, den_reg});
        if (req.start) begin
            busy_next = 1'b1;
            done_next = 1'b0;
            step_next = '0;
            rem_next  = req.total[TOTAL_W-1:8];
            sh_next   = {req.total[7:0], 8'h00};
            den_next  = {req.count, 1'b0} + {1'b0, req.count};
            q_next    = '0;
        end else if (busy_reg) begin
            rem_next  = fits ? rem_sub[DIVISOR_W-1:0] : rem_shift[DIVISOR_W-1:0];
            q_next    = {q_reg[FIT_W-2:0], fits};
            sh_next   = {sh_reg[FIT_W-2:0], 1'b0};
            step_next = step_reg + 4'd1;
            if (step_reg == 4'd15) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge aclk) begin
        rem_reg <= rem_next;
        den_reg <= den_next;
        sh_reg  <= sh_next;
        q_reg   <= q_next;
    end

    assign rsp.done     = done_reg;
    assign rsp.quotient = q_reg;

endmodule

### rtl/core/rpsf_checker.sv
`include "rgb_pixel_store_sad_fitness_macros.svh"

module rpsf_checker (
    input logic                          aclk,
    input logic                          aresetn,
    input logic                          m_valid,
    input logic                          m_ready,
    input logic [rpsf_pkg::STATUS_W-1:0] m_status,
    input logic [7:0]                    m_out_red,
    input logic [7:0]                    m_out_green,
    input logic [7:0]                    m_out_blue,
    input logic [rpsf_pkg::FIT_W-1:0]    m_fitness,
    input logic                          m_run_done
);
    import rpsf_pkg::*;

    logic pix_nonzero;

    assign pix_nonzero = (m_out_red != 8'd0) || (m_out_green != 8'd0) || (m_out_blue != 8'd0);

    `RPSF_ASSERT_NEXT(a_out_hold, m_valid && !m_ready, m_valid && $stable(m_status) && $stable(m_fitness) && $stable(m_run_done), "Result beat changed while stalled.")
    `RPSF_ASSERT_NOW(a_done_ok, m_valid && m_run_done, m_status == STATUS_OK && !pix_nonzero, "Run result carries a bad status or pixel data.")
    `RPSF_ASSERT_NOW(a_err_zero, m_valid && m_status != STATUS_OK, m_fitness == '0 && !pix_nonzero && !m_run_done, "Error result carries data.")
    `RPSF_ASSERT_NOW(a_read_only, m_valid && pix_nonzero, m_fitness == '0 && !m_run_done, "Pixel data mixed with fitness.")

endmodule

bind rgb_pixel_store_sad_fitness rpsf_checker u_rpsf_checker (
    .aclk        (aclk),
    .aresetn     (aresetn),
    .m_valid     (m_valid),
    .m_ready     (m_ready),
    .m_status    (m_status),
    .m_out_red   (m_out_red),
    .m_out_green (m_out_green),
    .m_out_blue  (m_out_blue),
    .m_fitness   (m_fitness),
    .m_run_done  (m_run_done)
);

### tb/sv/tb_rgb_pixel_store_sad_fitness.sv
`timescale 1ns / 100ps

module tb_rgb_pixel_store_sad_fitness;
    import rpsf_pkg::*;

    localparam int HOLD_CYCLES = 300;
    localparam int MAX_REPORTS = 10;
    localparam int SETTLE_CYCLES = 24;

    typedef struct packed {
        logic [1:0]        opcode;
        logic [ADDR_W-1:0] index;
        pixel_t            pix;
        logic              last;
    } pixel_op_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        pixel_t              pix;
        logic [FIT_W-1:0]    fitness;
        logic                run_done;
    } pixel_result_t;

    logic                aclk = 1'b0;
    logic                aresetn = 1'b0;
    logic                cfg_valid = 1'b0;
    logic                cfg_ready;
    logic [COUNT_W-1:0]  cfg_gene_count = '0;
    logic                s_valid = 1'b0;
    logic                s_ready;
    logic [1:0]          s_opcode = OP_WRITE;
    logic [ADDR_W-1:0]   s_pixel_index = '0;
    logic [7:0]          s_red = '0;
    logic [7:0]          s_green = '0;
    logic [7:0]          s_blue = '0;
    logic                s_last_target = 1'b0;
    logic                m_valid;
    logic                m_ready = 1'b0;
    logic [STATUS_W-1:0] m_status;
    logic [7:0]          m_out_red;
    logic [7:0]          m_out_green;
    logic [7:0]          m_out_blue;
    logic [FIT_W-1:0]    m_fitness;
    logic                m_run_done;

    pixel_t             store_copy [PIXELS];
    logic [TOTAL_W-1:0] sad_total;
    logic [POS_W-1:0]   run_position;
    logic [COUNT_W-1:0] active_count;
    pixel_result_t      pending_results [$];

    int error_count = 0;
    int tx_idle_pct = 0;
    int rx_stall_pct = 0;
    int hold_requests = 0;
    int holds_seen = 0;
    int hold_left = 0;

    rgb_pixel_store_sad_fitness u_top (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_gene_count (cfg_gene_count),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_opcode       (s_opcode),
        .s_pixel_index  (s_pixel_index),
        .s_red          (s_red),
        .s_green        (s_green),
        .s_blue         (s_blue),
        .s_last_target  (s_last_target),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_status       (m_status),
        .m_out_red      (m_out_red),
        .m_out_green    (m_out_green),
        .m_out_blue     (m_out_blue),
        .m_fitness      (m_fitness),
        .m_run_done     (m_run_done)
    );

    initial begin
        forever #4 aclk = ~aclk;
    end

    initial begin
        #(40_000_000);
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    function automatic int chan_dist(logic [7:0] a, logic [7:0] b);
        return (a > b) ? int'(a) - int'(b) : int'(b) - int'(a);
    endfunction

    function automatic int sad_of(pixel_t a, pixel_t b);
        return chan_dist(a.red, b.red) + chan_dist(a.green, b.green)
             + chan_dist(a.blue, b.blue);
    endfunction

    function automatic bit index_valid(int idx);
        return idx < active_count && idx < PIXELS;
    endfunction

    function automatic pixel_result_t apply_pixel_op(pixel_op_t op);
        pixel_result_t res;
        int            pos;
        longint        count;
        res = '0;
        res.status = STATUS_OK;
        case (op.opcode)
            OP_WRITE: begin
                if (index_valid(op.index)) begin
                    store_copy[op.index] = op.pix;
                end else begin
                    res.status = STATUS_RANGE;
                end
            end
            OP_READ: begin
                if (index_valid(op.index)) begin
                    res.pix = store_copy[op.index];
                end else begin
                    res.status = STATUS_RANGE;
                end
            end
            OP_GENE: begin
                if (index_valid(op.index)) begin
                    res.fitness = FIT_W'((sad_of(store_copy[op.index], op.pix) * 65536) / 768);
                end else begin
                    res.status = STATUS_RANGE;
                end
            end
            OP_COMPARE: begin
                pos = run_position;
                if (index_valid(pos)) begin
                    sad_total = sad_total + TOTAL_W'(sad_of(store_copy[pos], op.pix));
                end
                if (op.last) begin
                    count = pos + 1;
                    if (count == active_count && active_count <= PIXELS) begin
                        res.fitness = FIT_W'((longint'(sad_total) * 65536) / (768 * count));
                        res.run_done = 1'b1;
                    end else begin
                        res.status = STATUS_MISMATCH;
                    end
                    sad_total = '0;
                    run_position = '0;
                end else if (run_position != POS_MAX) begin
                    run_position = run_position + 1'b1;
                end
            end
            default: ;
        endcase
        return res;
    endfunction

    function automatic logic [7:0] rand_channel();
        if ($urandom_range(3) == 0) begin
            return $urandom_range(1) ? 8'hFF : 8'h00;
        end
        return 8'($urandom_range(255));
    endfunction

    function automatic pixel_t rand_pixel();
        pixel_t p;
        p.red = rand_channel();
        p.green = rand_channel();
        p.blue = rand_channel();
        return p;
    endfunction

    always @(posedge aclk) begin
        if (hold_requests != holds_seen) begin
            holds_seen = hold_requests;
            hold_left = HOLD_CYCLES;
        end
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left--;
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= rx_stall_pct);
        end
    end

    always @(posedge aclk) begin
        pixel_result_t want;
        pixel_result_t got;
        if (aresetn && m_valid && m_ready) begin
            got = {m_status, m_out_red, m_out_green, m_out_blue, m_fitness, m_run_done};
            if (pending_results.size() == 0) begin
                error_count++;
                if (error_count <= MAX_REPORTS) begin
                    $display("%0t: result beat with nothing expected", $realtime);
                    $display("%0t: got status %0d rgb %h fitness %0d done %0d",
                             $realtime, got.status, got.pix, got.fitness, got.run_done);
                end
            end else begin
                want = pending_results.pop_front();
                if (got.status !== want.status || got.pix !== want.pix
                        || got.fitness !== want.fitness || got.run_done !== want.run_done) begin
                    error_count++;
                    if (error_count <= MAX_REPORTS) begin
                        $display("%0t: expected status %0d rgb %h fitness %0d done %0d",
                                 $realtime, want.status, want.pix, want.fitness,
                                 want.run_done);
                        $display("%0t: got      status %0d rgb %h fitness %0d done %0d",
                                 $realtime, got.status, got.pix, got.fitness, got.run_done);
                    end
                end
            end
        end
    end

    task automatic send_pixel_op(input logic [1:0] opcode, input int index, input pixel_t pix,
                                 input logic last);
        pixel_op_t op;
        op.opcode = opcode;
        op.index = ADDR_W'(index);
        op.pix = pix;
        op.last = last;
        while ($urandom_range(99) < tx_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_opcode <= op.opcode;
        s_pixel_index <= op.index;
        s_red <= op.pix.red;
        s_green <= op.pix.green;
        s_blue <= op.pix.blue;
        s_last_target <= op.last;
        do @(posedge aclk); while (!s_ready);
        pending_results.push_back(apply_pixel_op(op));
    endtask

    task automatic send_target(input logic last);
        send_pixel_op(OP_COMPARE, $urandom_range(1023), rand_pixel(), last);
    endtask

    // A run always starts at position zero, so a run left open by noise is closed first.
    task automatic send_compare_run(input int length);
        if (run_position != '0) begin
            send_target(1'b1);
        end
        for (int i = 0; i < length; i++) begin
            send_target(i == length - 1);
        end
    endtask

    task automatic wait_block_idle();
        s_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic set_gene_count(input int value);
        wait_block_idle();
        cfg_valid <= 1'b1;
        cfg_gene_count <= COUNT_W'(value);
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        active_count = COUNT_W'(value);
    endtask

    task automatic send_random_traffic(input int items);
        int limit;
        int sent;
        int pick;
        int len;
        limit = (active_count < PIXELS) ? int'(active_count) : PIXELS;
        sent = 0;
        while (sent < items) begin
            pick = $urandom_range(99);
            if (limit == 0 || pick >= 85) begin
                send_pixel_op(2'($urandom_range(3)), $urandom_range(1023), rand_pixel(),
                              1'($urandom_range(1)));
                sent++;
            end else if (pick < 20) begin
                send_pixel_op(OP_WRITE, $urandom_range(limit - 1), rand_pixel(), 1'b0);
                sent++;
            end else if (pick < 35) begin
                send_pixel_op(OP_READ, $urandom_range(limit - 1), rand_pixel(), 1'b0);
                sent++;
            end else if (pick < 50) begin
                send_pixel_op(OP_GENE, $urandom_range(limit - 1), rand_pixel(), 1'b0);
                sent++;
            end else if (pick < 75) begin
                len = (active_count <= 64) ? int'(active_count) : $urandom_range(1, 8);
                send_compare_run(len);
                sent += len;
            end else begin
                len = $urandom_range(1, (limit < 32) ? 2 * limit + 1 : 8);
                send_compare_run(len);
                sent += len;
            end
        end
    endtask

    task automatic test_directed();
        set_gene_count(4);
        send_pixel_op(OP_WRITE, 0, '{8'hFF, 8'hFF, 8'hFF}, 1'b1);
        send_pixel_op(OP_WRITE, 3, '{8'h00, 8'h80, 8'hFF}, 1'b0);
        send_pixel_op(OP_WRITE, 4, '{8'h12, 8'h34, 8'h56}, 1'b0);
        send_pixel_op(OP_WRITE, 1023, '{8'hFF, 8'h00, 8'hFF}, 1'b0);
        send_pixel_op(OP_READ, 0, '{8'h00, 8'h00, 8'h00}, 1'b0);
        send_pixel_op(OP_READ, 3, '{8'hFF, 8'hFF, 8'hFF}, 1'b0);
        send_pixel_op(OP_READ, 1, '{8'h00, 8'h00, 8'h00}, 1'b0);
        send_pixel_op(OP_READ, 4, '{8'h00, 8'h00, 8'h00}, 1'b0);
        send_pixel_op(OP_GENE, 0, '{8'h00, 8'h00, 8'h00}, 1'b0);
        send_pixel_op(OP_GENE, 1, '{8'hFF, 8'hFF, 8'hFF}, 1'b0);
        send_pixel_op(OP_GENE, 3, '{8'h00, 8'h80, 8'hFF}, 1'b0);
        send_pixel_op(OP_GENE, 1023, '{8'hFF, 8'hFF, 8'hFF}, 1'b0);
        send_compare_run(4);
        send_compare_run(2);
        send_compare_run(5);
    endtask

    task automatic test_idling_phases();
        tx_idle_pct = 0;
        rx_stall_pct = 0;
        set_gene_count(1);
        send_random_traffic(100);
        tx_idle_pct = 86;
        set_gene_count(7);
        send_random_traffic(120);
        tx_idle_pct = 0;
        rx_stall_pct = 86;
        set_gene_count(16);
        send_random_traffic(120);
        tx_idle_pct = 17;
        rx_stall_pct = 17;
        set_gene_count($urandom_range(2, 40));
        send_random_traffic(120);
        tx_idle_pct = 0;
        rx_stall_pct = 0;
    endtask

    task automatic test_input_backpressure();
        set_gene_count(12);
        hold_requests++;
        send_random_traffic(60);
    endtask

    task automatic test_full_store();
        set_gene_count(1024);
        send_pixel_op(OP_WRITE, 1023, '{8'hFF, 8'hFF, 8'hFF}, 1'b0);
        send_pixel_op(OP_READ, 1023, '{8'h00, 8'h00, 8'h00}, 1'b0);
        for (int i = 0; i < 16; i++) begin
            send_pixel_op(OP_WRITE, $urandom_range(1023), rand_pixel(), 1'b0);
        end
        send_compare_run(1024);
        send_random_traffic(20);
    endtask

    task automatic test_odd_counts();
        set_gene_count(0);
        send_random_traffic(40);
        send_compare_run(1);
        set_gene_count(2047);
        send_random_traffic(40);
        set_gene_count(1025);
        send_compare_run(3);
        // The count is changed while a run is open; the run keeps its position.
        set_gene_count(3);
        send_compare_run(0);
        send_target(1'b0);
        send_target(1'b0);
        set_gene_count(5);
        send_target(1'b0);
        send_target(1'b0);
        send_target(1'b1);
    endtask

    initial begin
        for (int i = 0; i < PIXELS; i++) begin
            store_copy[i] = '0;
        end
        sad_total = '0;
        run_position = '0;
        active_count = GENE_COUNT_RESET;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        test_directed();
        test_idling_phases();
        test_input_backpressure();
        test_full_store();
        test_odd_counts();
        wait_block_idle();
        if (error_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

### sim.f
+incdir+rtl/core
rtl/core/rpsf_pkg.sv
rtl/core/rpsf_ram.sv
rtl/core/rpsf_div.sv
rtl/core/rgb_pixel_store_sad_fitness.sv
rtl/core/rpsf_checker.sv
tb/sv/tb_rgb_pixel_store_sad_fitness.sv
